### src/rle8_bitmap_decoder_unit_macros.svh
// Assertion macros for the RLE8 bitmap decoder unit.
`ifndef RLE8_BITMAP_DECODER_UNIT_MACROS_SVH
`define RLE8_BITMAP_DECODER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Condition implies consequence in the same cycle.
`define RLE8_ASSERT_IMPLIES(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("rle8 decoder: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define RLE8_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("rle8 decoder: next-cycle check failed");

`else

`define RLE8_ASSERT_IMPLIES(label, clk, rst, cond, cons)
`define RLE8_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

### src/rle8_pkg.sv
// Shared types and constants of the RLE8 bitmap decoder unit.
`timescale 1ns / 1ps

package rle8_pkg;

   // Coordinate width default and fixed field widths
   localparam int COORD_BITS_DEF = 16;
   localparam int LINES_BITS     = 16;
   localparam int ROW_BITS       = LINES_BITS + 1;
   localparam int OUT_COORD_BITS = 16;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   // Register word index on the configuration port
   localparam logic REG_IMAGE_LINES = 1'b0;

   // Escape codes following a zero length byte
   localparam logic [7:0] ESC_EOL   = 8'd0;
   localparam logic [7:0] ESC_EOB   = 8'd1;
   localparam logic [7:0] ESC_DELTA = 8'd2;

   // Parse phase
   typedef enum logic [2:0] {
      PH_LEN   = 3'd0,
      PH_COLOR = 3'd1,
      PH_ESC   = 3'd2,
      PH_DX    = 3'd3,
      PH_DY    = 3'd4,
      PH_ABS   = 3'd5,
      PH_PAD   = 3'd6
   } phase_type;

   // One run descriptor
   typedef struct packed {
      logic [OUT_COORD_BITS-1:0] x_start;
      logic [OUT_COORD_BITS-1:0] row;
      logic [7:0]                run_length;
      logic [7:0]                palette_idx;
      logic                      picture_end;
   } result_type;

endpackage

### src/rle8_bitmap_decoder_unit.sv
// Top level of the RLE8 bitmap decoder unit: byte parser, result queue and CSR.
//
//   channel | ports                         | dir | transfer when
//   --------+-------------------------------+-----+---------------------------
//   req     | req_valid/req_stall, req_*    | in  | req_valid & !req_stall
//   rsp     | rsp_valid/rsp_stall, rsp_*    | out | rsp_valid & !rsp_stall
//   csr     | psel/penable/pwrite/paddr/... | in  | psel & penable & pwrite
//
// One byte per cycle while req_stall is low: the parser state updates in the cycle of the
// transfer and a result, if any, is registered onto rsp, or into the skid entry if rsp is held.
// An output register plus a one-entry skid buffer decouple the two channels;
// req_stall rises only while the skid entry is occupied.
// Synchronous reset clears the parser to "finished" (bytes are ignored until a
// byte with req_first_byte set) and image_lines to 1.
`timescale 1ns / 1ps
`include "rle8_bitmap_decoder_unit_macros.svh"

module rle8_bitmap_decoder_unit #(
   parameter int COORD_BITS = rle8_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_first_byte,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rle8_pkg::OUT_COORD_BITS-1:0]  rsp_x_start,
   output logic [rle8_pkg::OUT_COORD_BITS-1:0]  rsp_row,
   output logic [7:0]                           rsp_run_length,
   output logic [7:0]                           rsp_palette_idx,
   output logic                                 rsp_picture_end,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [rle8_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [rle8_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [rle8_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   localparam int RB = rle8_pkg::ROW_BITS;
   localparam int LB = rle8_pkg::LINES_BITS;

   // Configuration register
   logic [LB-1:0] image_lines_ff, image_lines_in;
   logic          reg_hit;

   // Parser state
   rle8_pkg::phase_type   phase_ff, phase_in;
   logic [COORD_BITS-1:0] column_ff, column_in;
   logic [RB-1:0]         row_ff, row_in;
   logic [7:0]            pending_ff, pending_in;
   logic                  odd_pad_ff, odd_pad_in;
   logic                  finished_ff, finished_in;

   // Result queue: output register and skid entry
   rle8_pkg::result_type  out_ff, out_in, skid_ff, skid_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;

   logic                  req_accept, rsp_take;
   logic                  res_valid;
   rle8_pkg::result_type  res;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid & ~skid_valid_ff;
   assign rsp_take   = out_valid_ff & ~rsp_stall;

   // CSR access
   assign pready  = 1'b1;
   assign reg_hit = paddr[rle8_pkg::CSR_ADDR_BITS-1] == rle8_pkg::REG_IMAGE_LINES;
   assign prdata  = reg_hit ? rle8_pkg::CSR_DATA_BITS'(image_lines_ff) : '0;

   always_comb begin
      image_lines_in = image_lines_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         image_lines_in = pwdata[LB-1:0];
      end
   end

   // Byte parser
   always_comb begin
      logic skip;
      skip        = 1'b0;
      phase_in    = phase_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      pending_in  = pending_ff;
      odd_pad_in  = odd_pad_ff;
      finished_in = finished_ff;
      res_valid   = 1'b0;
      res         = '0;

      if (req_accept) begin
         // new bitmap: restart position and phase
         if (req_first_byte) begin
            phase_in    = rle8_pkg::PH_LEN;
            column_in   = '0;
            pending_in  = '0;
            odd_pad_in  = 1'b0;
            finished_in = 1'b0;
            if (image_lines_ff == '0) begin
               row_in      = '1;
               finished_in = 1'b1;
               res_valid   = 1'b1;
               res.picture_end = 1'b1;
               skip        = 1'b1;
            end else begin
               row_in = RB'(image_lines_ff) - RB'(1);
            end
         end

         if (!skip && !finished_in) begin
            unique case (phase_in)
               rle8_pkg::PH_LEN: begin
                  if (req_data_byte != 8'd0) begin
                     pending_in = req_data_byte;
                     phase_in   = rle8_pkg::PH_COLOR;
                  end else begin
                     phase_in = rle8_pkg::PH_ESC;
                  end
               end
               rle8_pkg::PH_COLOR: begin
                  res_valid       = 1'b1;
                  res.x_start     = rle8_pkg::OUT_COORD_BITS'(column_in);
                  res.row         = rle8_pkg::OUT_COORD_BITS'(row_in[COORD_BITS-1:0]);
                  res.run_length  = pending_in;
                  res.palette_idx = req_data_byte;
                  column_in       = column_in + COORD_BITS'(pending_in);
                  pending_in      = '0;
                  phase_in        = rle8_pkg::PH_LEN;
               end
               rle8_pkg::PH_ESC: begin
                  phase_in = rle8_pkg::PH_LEN;
                  priority if (req_data_byte == rle8_pkg::ESC_EOL) begin
                     column_in = '0;
                     row_in    = row_in - RB'(1);
                     if (row_in[RB-1]) begin
                        finished_in     = 1'b1;
                        res_valid       = 1'b1;
                        res.picture_end = 1'b1;
                     end
                  end else if (req_data_byte == rle8_pkg::ESC_EOB) begin
                     finished_in     = 1'b1;
                     res_valid       = 1'b1;
                     res.picture_end = 1'b1;
                  end else if (req_data_byte == rle8_pkg::ESC_DELTA) begin
                     phase_in = rle8_pkg::PH_DX;
                  end else begin
                     pending_in = req_data_byte;
                     odd_pad_in = req_data_byte[0];
                     phase_in   = rle8_pkg::PH_ABS;
                  end
               end
               rle8_pkg::PH_DX: begin
                  column_in = column_in + COORD_BITS'(req_data_byte);
                  phase_in  = rle8_pkg::PH_DY;
               end
               rle8_pkg::PH_DY: begin
                  row_in   = row_in - RB'(req_data_byte);
                  phase_in = rle8_pkg::PH_LEN;
                  if (row_in[RB-1]) begin
                     finished_in     = 1'b1;
                     res_valid       = 1'b1;
                     res.picture_end = 1'b1;
                  end
               end
               rle8_pkg::PH_ABS: begin
                  // one result per literal pixel
                  res_valid       = 1'b1;
                  res.x_start     = rle8_pkg::OUT_COORD_BITS'(column_in);
                  res.row         = rle8_pkg::OUT_COORD_BITS'(row_in[COORD_BITS-1:0]);
                  res.run_length  = 8'd1;
                  res.palette_idx = req_data_byte;
                  column_in       = column_in + COORD_BITS'(1);
                  pending_in      = pending_in - 8'd1;
                  if (pending_in == 8'd0) begin
                     phase_in   = odd_pad_in ? rle8_pkg::PH_PAD : rle8_pkg::PH_LEN;
                     odd_pad_in = 1'b0;
                  end
               end
               default: begin
                  // pad byte after an odd literal run, or an unused code
                  phase_in = rle8_pkg::PH_LEN;
               end
            endcase
         end
      end
   end

   // Result queue next state
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_lines_ff <= LB'(1);
         phase_ff       <= rle8_pkg::PH_LEN;
         column_ff      <= '0;
         row_ff         <= '0;
         pending_ff     <= '0;
         odd_pad_ff     <= 1'b0;
         finished_ff    <= 1'b1;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         image_lines_ff <= image_lines_in;
         phase_ff       <= phase_in;
         column_ff      <= column_in;
         row_ff         <= row_in;
         pending_ff     <= pending_in;
         odd_pad_ff     <= odd_pad_in;
         finished_ff    <= finished_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_x_start     = out_ff.x_start;
   assign rsp_row         = out_ff.row;
   assign rsp_run_length  = out_ff.run_length;
   assign rsp_palette_idx = out_ff.palette_idx;
   assign rsp_picture_end = out_ff.picture_end;

   // Checks
   `RLE8_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `RLE8_ASSERT_NEXT(a_end_sets_finished, clock, reset, res_valid && res.picture_end, finished_ff)
   `RLE8_ASSERT_IMPLIES(a_run_not_empty, clock, reset, rsp_valid && !rsp_picture_end, rsp_run_length != 8'd0)

endmodule

### verif/testbench.sv
// Self-checking testbench for the RLE8 bitmap decoder unit: run prediction and scoring.
`timescale 1ns / 1ps

module testbench;

   // Marker byte that opens every escape sequence
   localparam logic [7:0] ESC_MARK = 8'd0;
   localparam int HOLD_CYCLES = 300;

   // Predicts the run descriptors of the decoder and scores the ones it delivers.
   class run_predictor;
      logic [15:0]          lines;
      rle8_pkg::phase_type  phase;
      logic [15:0]          column;
      int                   row_pos;
      logic [7:0]           count;
      bit                   odd_pad;
      bit                   halted;
      rle8_pkg::result_type runs_due[$];
      int                   errors;

      function new();
         lines   = 16'd1;
         phase   = rle8_pkg::PH_LEN;
         column  = '0;
         row_pos = 0;
         count   = '0;
         odd_pad = 1'b0;
         halted  = 1'b1;
         errors  = 0;
      endfunction

      function void push_run(logic [7:0] len, logic [7:0] color);
         rle8_pkg::result_type r;
         r.x_start     = column;
         r.row         = row_pos[15:0];
         r.run_length  = len;
         r.palette_idx = color;
         r.picture_end = 1'b0;
         runs_due.push_back(r);
      endfunction

      function void push_end();
         rle8_pkg::result_type r;
         r = '0;
         r.picture_end = 1'b1;
         halted = 1'b1;
         runs_due.push_back(r);
      endfunction

      // Note one accepted byte and queue the descriptor it causes, if any
      function void take_byte(logic [7:0] b, logic first);
         if (first) begin
            phase   = rle8_pkg::PH_LEN;
            column  = '0;
            count   = '0;
            odd_pad = 1'b0;
            halted  = 1'b0;
            if (lines == 16'd0) begin
               row_pos = -1;
               push_end();
               return;
            end
            row_pos = int'(lines) - 1;
         end
         if (halted)
            return;
         case (phase)
            rle8_pkg::PH_LEN: begin
               if (b != 8'd0) begin
                  count = b;
                  phase = rle8_pkg::PH_COLOR;
               end else begin
                  phase = rle8_pkg::PH_ESC;
               end
            end
            rle8_pkg::PH_COLOR: begin
               push_run(count, b);
               column = column + 16'(count);
               count  = '0;
               phase  = rle8_pkg::PH_LEN;
            end
            rle8_pkg::PH_ESC: begin
               phase = rle8_pkg::PH_LEN;
               if (b == rle8_pkg::ESC_EOL) begin
                  column  = '0;
                  row_pos = row_pos - 1;
                  if (row_pos < 0)
                     push_end();
               end else if (b == rle8_pkg::ESC_EOB) begin
                  push_end();
               end else if (b == rle8_pkg::ESC_DELTA) begin
                  phase = rle8_pkg::PH_DX;
               end else begin
                  count   = b;
                  odd_pad = b[0];
                  phase   = rle8_pkg::PH_ABS;
               end
            end
            rle8_pkg::PH_DX: begin
               column = column + 16'(b);
               phase  = rle8_pkg::PH_DY;
            end
            rle8_pkg::PH_DY: begin
               row_pos = row_pos - int'(b);
               phase   = rle8_pkg::PH_LEN;
               if (row_pos < 0)
                  push_end();
            end
            rle8_pkg::PH_ABS: begin
               push_run(8'd1, b);
               column = column + 16'd1;
               count  = count - 8'd1;
               if (count == 8'd0) begin
                  if (odd_pad)
                     phase = rle8_pkg::PH_PAD;
                  else
                     phase = rle8_pkg::PH_LEN;
                  odd_pad = 1'b0;
               end
            end
            default: phase = rle8_pkg::PH_LEN;
         endcase
      endfunction

      // Compare one delivered descriptor with the oldest one predicted
      function void check_run(rle8_pkg::result_type got);
         rle8_pkg::result_type want;
         if (runs_due.size() == 0) begin
            $display("%0t: unexpected run: x=%0d row=%0d len=%0d pal=%0d end=%0b", $time,
                     got.x_start, got.row, got.run_length, got.palette_idx, got.picture_end);
            errors++;
            return;
         end
         want = runs_due.pop_front();
         if (got !== want) begin
            $display("%0t: run mismatch: expected x=%0d row=%0d len=%0d pal=%0d end=%0b",
                     $time, want.x_start, want.row, want.run_length, want.palette_idx,
                     want.picture_end);
            $display("%0t:               actual x=%0d row=%0d len=%0d pal=%0d end=%0b",
                     $time, got.x_start, got.row, got.run_length, got.palette_idx,
                     got.picture_end);
            errors++;
         end
      endfunction
   endclass

   // Clock, reset and block ports
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_data_byte = '0;
   logic                                req_first_byte = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [rle8_pkg::OUT_COORD_BITS-1:0] rsp_x_start;
   logic [rle8_pkg::OUT_COORD_BITS-1:0] rsp_row;
   logic [7:0]                          rsp_run_length;
   logic [7:0]                          rsp_palette_idx;
   logic                                rsp_picture_end;
   logic                                psel = 1'b0;
   logic                                penable = 1'b0;
   logic                                pwrite = 1'b0;
   logic [rle8_pkg::CSR_ADDR_BITS-1:0]  paddr = '0;
   logic [rle8_pkg::CSR_DATA_BITS-1:0]  pwdata = '0;
   logic [rle8_pkg::CSR_DATA_BITS-1:0]  prdata;
   logic                                pready;

   run_predictor predictor = new();
   logic [7:0]   byte_plan[$];
   bit           sender_steady = 1'b0;
   int           hold_requests = 0;
   int           holds_started = 0;
   int           bytes_sent = 0;

   rle8_bitmap_decoder_unit dut (.*);

   always #5 clock = ~clock;

   // Gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 96)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Offer one byte and wait for its transfer
   task automatic send_byte(input logic [7:0] value, input logic first);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= value;
      req_first_byte <= first;
      do
         @(posedge clock);
      while (req_stall);
      predictor.take_byte(value, first);
      bytes_sent++;
   endtask

   task automatic send_plan();
      for (int i = 0; i < byte_plan.size(); i++)
         send_byte(byte_plan[i], i == 0);
   endtask

   // Drop valid, drain all predicted runs, then let the parser go quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predictor.runs_due.size() != 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // Register write: setup cycle, then access cycle
   task automatic set_image_lines(input logic [15:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= rle8_pkg::CSR_ADDR_BITS'(4 * int'(rle8_pkg::REG_IMAGE_LINES));
      pwdata  <= rle8_pkg::CSR_DATA_BITS'(value);
      @(negedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      predictor.lines = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Random content of one scan line: encoded runs, absolute runs and deltas
   function automatic void plan_line();
      int pieces;
      int kind;
      int n;
      pieces = $urandom_range(1, 5);
      for (int p = 0; p < pieces; p++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            byte_plan.push_back(8'($urandom_range(1, 255)));
            byte_plan.push_back(8'($urandom));
         end else if (kind < 8) begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 9);
            byte_plan.push_back(ESC_MARK);
            byte_plan.push_back(8'(n));
            for (int k = 0; k < n; k++)
               byte_plan.push_back(8'($urandom));
            if (n % 2 == 1)
               byte_plan.push_back(8'($urandom));
         end else begin
            byte_plan.push_back(ESC_MARK);
            byte_plan.push_back(rle8_pkg::ESC_DELTA);
            byte_plan.push_back(8'($urandom));
            byte_plan.push_back(($urandom_range(0, 5) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 2)));
         end
      end
   endfunction

   // One bitmap, a truncated bitmap, or a burst of noise
   function automatic void plan_bitmap();
      int nlines;
      int r;
      byte_plan.delete();
      r = $urandom_range(0, 9);
      if (r == 0) begin
         // noise: random bytes, now and then flagged as a first byte
         nlines = $urandom_range(3, 12);
         for (int k = 0; k < nlines; k++)
            byte_plan.push_back(8'($urandom));
         return;
      end
      if (predictor.lines <= 16'd4 && $urandom_range(0, 1) == 1)
         nlines = int'(predictor.lines);
      else
         nlines = $urandom_range(0, 4);
      for (int l = 0; l < nlines; l++) begin
         plan_line();
         byte_plan.push_back(ESC_MARK);
         byte_plan.push_back(rle8_pkg::ESC_EOL);
      end
      r = $urandom_range(0, 9);
      if (r < 7) begin
         byte_plan.push_back(ESC_MARK);
         byte_plan.push_back(rle8_pkg::ESC_EOB);
      end else if (r < 9) begin
         byte_plan.push_back(ESC_MARK);
         byte_plan.push_back(rle8_pkg::ESC_DELTA);
         byte_plan.push_back(8'($urandom));
         byte_plan.push_back(8'($urandom_range(128, 255)));
      end
      if (byte_plan.size() == 0)
         plan_line();
      // broken stream: cut it short, the next first byte restarts the parser
      if ($urandom_range(0, 7) == 0)
         while (byte_plan.size() > 1 && byte_plan.size() > $urandom_range(1, 8))
            void'(byte_plan.pop_back());
   endfunction

   task automatic send_noise();
      for (int i = 0; i < byte_plan.size(); i++)
         send_byte(byte_plan[i], $urandom_range(0, 5) == 0);
   endtask

   // One line wide enough to wrap the column, sent back to back
   function automatic void plan_wide_line();
      byte_plan.delete();
      for (int k = 0; k < 262; k++) begin
         byte_plan.push_back(8'($urandom_range(251, 255)));
         byte_plan.push_back(8'($urandom));
      end
      byte_plan.push_back(ESC_MARK);
      byte_plan.push_back(rle8_pkg::ESC_DELTA);
      byte_plan.push_back(8'hFF);
      byte_plan.push_back(8'h00);
      byte_plan.push_back(ESC_MARK);
      byte_plan.push_back(rle8_pkg::ESC_EOL);
      byte_plan.push_back(8'h07);
      byte_plan.push_back(8'($urandom));
      byte_plan.push_back(ESC_MARK);
      byte_plan.push_back(rle8_pkg::ESC_EOB);
   endfunction

   // Score every descriptor transfer
   always @(posedge clock) begin
      rle8_pkg::result_type seen;
      seen = {rsp_x_start, rsp_row, rsp_run_length, rsp_palette_idx, rsp_picture_end};
      if (!reset && rsp_valid && !rsp_stall)
         predictor.check_run(seen);
   end

   // Receiver: random stalls, quiet stretches, and a long hold-off on request
   initial begin : receiver
      int stall_left;
      int free_left;
      int hold_left;
      stall_left = 0;
      free_left  = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (holds_started != hold_requests) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            rsp_stall  <= 1'b0;
            stall_left = pick_gap();
            free_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      logic [15:0] phase_lines[$];
      int          budget;
      int          phase_start;
      phase_lines = '{16'd65535, 16'd1, 16'd3, 16'd0, 16'd2,
                      16'($urandom_range(1, 65535)), 16'd40};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, one line high (reset value): bytes before any first byte are ignored
      send_byte(8'h05, 1'b0);
      send_byte(ESC_MARK, 1'b0);
      // longest encoded run, then a short one
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hFF, 1'b0);
      // odd absolute run with its pad byte
      send_byte(ESC_MARK, 1'b0);
      send_byte(8'd3, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'h0F, 1'b0);
      send_byte(8'h77, 1'b0);
      // delta on row zero does not end the picture
      send_byte(ESC_MARK, 1'b0);
      send_byte(rle8_pkg::ESC_DELTA, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // end of line takes the row below zero, later bytes are ignored
      send_byte(ESC_MARK, 1'b0);
      send_byte(rle8_pkg::ESC_EOL, 1'b0);
      send_byte(8'h10, 1'b0);
      settle();

      // zero lines: first byte ends the picture at once
      set_image_lines(16'd0);
      send_byte(8'h42, 1'b1);
      send_byte(ESC_MARK, 1'b0);
      settle();

      // tallest picture: escape on the first byte, deep delta, end of bitmap
      set_image_lines(16'd65535);
      send_byte(ESC_MARK, 1'b1);
      send_byte(rle8_pkg::ESC_DELTA, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(ESC_MARK, 1'b0);
      send_byte(rle8_pkg::ESC_EOB, 1'b0);
      settle();

      // Random phases, one per line count
      foreach (phase_lines[p]) begin
         set_image_lines(phase_lines[p]);
         if (p == 0) begin
            // receiver holds off while runs pile up and the input backs up
            plan_wide_line();
            sender_steady = 1'b1;
            hold_requests++;
            send_plan();
         end
         budget      = (phase_lines[p] == 16'd0) ? 6 : 10;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < budget) begin
            sender_steady = ($urandom_range(0, 3) == 0);
            plan_bitmap();
            if (byte_plan.size() > 0 && byte_plan[0] != ESC_MARK && $urandom_range(0, 9) == 0)
               send_noise();
            else
               send_plan();
         end
         sender_steady = 1'b0;
         settle();
      end

      // settle() only returns once every predicted run has arrived
      if (predictor.errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

   // Run limit
   initial begin : watchdog
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

### rle8_bitmap_decoder_unit.f
+incdir+src
src/rle8_pkg.sv
src/rle8_bitmap_decoder_unit.sv
verif/testbench.sv
